// File: rtl/compass_heading_from_xy_assert.svh
// Assertion macros for the compass heading pipeline.
`ifndef COMPASS_HEADING_FROM_XY_ASSERT_SVH
`define COMPASS_HEADING_FROM_XY_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define CHXY_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define CHXY_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/chxy_pkg.sv
// Shared types, register codes and constants of the compass heading pipeline.
package chxy_pkg;

    localparam int GAIN_W     = 15;
    localparam int COEF_W     = 16;
    localparam int HOFF_W     = 10;
    localparam int CORR_W     = 16;
    localparam int HEAD_W     = 9;
    localparam int ANG_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_TDATA_W = 56;

    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_W     = 33;
    localparam int Z_W          = 27;

    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_PHI        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_COS_PHI    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_OFFSET = 3'd6;

    localparam logic [COEF_W-1:0] INV_COS_RESET = 16'd8192;

    localparam logic [16:0] ANGLE_SCALE   = 17'd90000;
    localparam logic [18:0] ANGLE_RECIP   = 19'd427445;
    localparam logic [12:0] TENTH_RECIP   = 13'd6554;
    localparam logic [ANG_W-1:0] QUARTER_TURN = 12'd900;
    localparam logic [ANG_W-1:0] HALF_TURN    = 12'd1800;
    localparam logic [ANG_W-1:0] FULL_TURN    = 12'd3600;
    localparam logic signed [12:0] HEAD_BASE  = 13'sd1530;
    localparam logic signed [12:0] DEG_360    = 13'sd360;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
    } sign_t;

    typedef struct packed {
        logic                     x_neg;
        logic                     y_neg;
        logic signed [CORR_W-1:0] corr_x;
        logic signed [CORR_W-1:0] corr_y;
    } side_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] cx;
        logic signed [CORDIC_W-1:0] cy;
        logic signed [Z_W-1:0]      z;
        side_t                      side;
    } cordic_t;

    function automatic logic signed [Z_W-1:0] atan_step(input int idx);
        logic signed [Z_W-1:0] res;
        case (idx)
            0:  res = 27'sd13176795;
            1:  res = 27'sd7778716;
            2:  res = 27'sd4110060;
            3:  res = 27'sd2086331;
            4:  res = 27'sd1047214;
            5:  res = 27'sd524117;
            6:  res = 27'sd262123;
            7:  res = 27'sd131069;
            8:  res = 27'sd65536;
            9:  res = 27'sd32768;
            10: res = 27'sd16384;
            11: res = 27'sd8192;
            12: res = 27'sd4096;
            13: res = 27'sd2048;
            14: res = 27'sd1024;
            15: res = 27'sd512;
            16: res = 27'sd256;
            17: res = 27'sd128;
            18: res = 27'sd64;
            19: res = 27'sd32;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/compass_heading_from_xy.sv
// Compass heading from calibrated X/Y magnetometer samples, fully pipelined.
// Throughput: one transaction per cycle while the output is not held, through 5 calibration stages, a divider chain of
//   SAMPLE_WIDTH + 20 cells, one saturation stage, 20 CORDIC cells and 4 finishing stages.
// A held output transaction stalls the whole pipeline; input is taken whenever it advances.
// Reset clears all valid flags and returns the configuration registers to their reset defaults.
module compass_heading_from_xy #(
    parameter int SAMPLE_WIDTH = 16,
    localparam int IN_TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [IN_TDATA_W-1:0]                s_tdata,   // raw_x, raw_y
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [chxy_pkg::OUT_TDATA_W-1:0]     m_tdata,   // heading_deg, angle_tenths,
                                                            // corrected_x, corrected_y
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [chxy_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [chxy_pkg::CFG_DATA_W-1:0]      cfg_data
);

    `include "compass_heading_from_xy_assert.svh"

    localparam int SW    = SAMPLE_WIDTH;
    localparam int DIV_W = SAMPLE_WIDTH + 20;
    localparam int GW    = chxy_pkg::GAIN_W;
    localparam int NCS   = chxy_pkg::CORDIC_STEPS;

    logic signed [SW-1:0]                 x_offset_reg, y_offset_reg;
    logic [GW-1:0]                        x_gain_reg, y_gain_reg, gx, gy;
    logic signed [chxy_pkg::COEF_W-1:0]   sin_phi_reg;
    logic [chxy_pkg::COEF_W-1:0]          inv_cos_phi_reg;
    logic signed [chxy_pkg::HOFF_W-1:0]   heading_offset_reg;

    logic adv;

    logic [DIV_W:0]    div_valid;
    logic [GW-1:0]     div_xr [0:DIV_W];
    logic [DIV_W-1:0]  div_xw [0:DIV_W];
    logic [GW-1:0]     div_yr [0:DIV_W];
    logic [DIV_W-1:0]  div_yw [0:DIV_W];
    chxy_pkg::sign_t   div_sgn [0:DIV_W];

    logic [NCS:0]       cor_valid;
    chxy_pkg::cordic_t  cor [0:NCS];
    chxy_pkg::cordic_t  cor0_next;

    logic signed [chxy_pkg::CORR_W-1:0] cxv, cyv, axv, ayv;
    logic [chxy_pkg::CORR_W:0]          axm, aym;

    logic [3:0]                  fin_valid_reg;
    chxy_pkg::side_t             f1_side_reg, f2_side_reg, f3_side_reg;
    logic [18:0]                 v_reg;
    logic [25:0]                 zc;
    logic [42:0]                 zprod;
    logic [37:0]                 rprod;
    logic [chxy_pkg::ANG_W-1:0]  araw_reg, a_clamp, ang_next, ang_reg;
    logic [24:0]                 tprod;
    logic signed [12:0]          hsum, hmod;
    logic [chxy_pkg::ANG_W-1:0]  out_ang_reg;
    logic [chxy_pkg::HEAD_W-1:0] out_head_reg;
    logic signed [chxy_pkg::CORR_W-1:0] out_cx_reg, out_cy_reg;

    function automatic logic signed [chxy_pkg::CORR_W-1:0] sat_mag(
        input logic [DIV_W-1:0] mag,
        input logic             neg
    );
        logic signed [chxy_pkg::CORR_W-1:0] res;
        if (neg)
        begin
            if (mag > DIV_W'(32768))
                res = 16'sh8000;
            else
                res = $signed(16'(~mag[15:0] + 16'd1));
        end
        else
        begin
            if (mag > DIV_W'(32767))
                res = 16'sh7FFF;
            else
                res = $signed(mag[15:0]);
        end
        return res;
    endfunction

    assign cfg_ready = 1'b1;
    assign gx = (x_gain_reg == '0) ? GW'(1) : x_gain_reg;
    assign gy = (y_gain_reg == '0) ? GW'(1) : y_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg       <= '0;
            y_offset_reg       <= '0;
            x_gain_reg         <= GW'(1);
            y_gain_reg         <= GW'(1);
            sin_phi_reg        <= '0;
            inv_cos_phi_reg    <= chxy_pkg::INV_COS_RESET;
            heading_offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                chxy_pkg::REG_X_OFFSET:       x_offset_reg       <= cfg_data[SW-1:0];
                chxy_pkg::REG_Y_OFFSET:       y_offset_reg       <= cfg_data[SW-1:0];
                chxy_pkg::REG_X_GAIN:         x_gain_reg         <= cfg_data[GW-1:0];
                chxy_pkg::REG_Y_GAIN:         y_gain_reg         <= cfg_data[GW-1:0];
                chxy_pkg::REG_SIN_PHI:        sin_phi_reg        <= cfg_data[15:0];
                chxy_pkg::REG_INV_COS_PHI:    inv_cos_phi_reg    <= cfg_data[15:0];
                chxy_pkg::REG_HEADING_OFFSET: heading_offset_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign adv      = m_tready | ~m_tvalid;
    assign s_tready = adv;

    chxy_calib #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_calib (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_valid    (s_tvalid),
        .raw_x       (s_tdata[SW-1:0]),
        .raw_y       (s_tdata[2*SW-1:SW]),
        .x_offset    (x_offset_reg),
        .y_offset    (y_offset_reg),
        .gx          (gx),
        .gy          (gy),
        .sin_phi     (sin_phi_reg),
        .inv_cos_phi (inv_cos_phi_reg),
        .out_valid   (div_valid[0]),
        .x_word      (div_xw[0]),
        .y_word      (div_yw[0]),
        .sgn         (div_sgn[0])
    );

    assign div_xr[0] = '0;
    assign div_yr[0] = '0;

    for (genvar k = 0; k < DIV_W; k++)
    begin : g_div
        chxy_div_cell #(
            .DIV_W (DIV_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .gy        (gy),
            .in_valid  (div_valid[k]),
            .x_rem_in  (div_xr[k]),
            .x_w_in    (div_xw[k]),
            .y_rem_in  (div_yr[k]),
            .y_w_in    (div_yw[k]),
            .sgn_in    (div_sgn[k]),
            .out_valid (div_valid[k+1]),
            .x_rem_out (div_xr[k+1]),
            .x_w_out   (div_xw[k+1]),
            .y_rem_out (div_yr[k+1]),
            .y_w_out   (div_yw[k+1]),
            .sgn_out   (div_sgn[k+1])
        );
    end

    always_comb
    begin
        cxv = sat_mag(div_xw[DIV_W], div_sgn[DIV_W].x_neg);
        cyv = sat_mag(div_yw[DIV_W], div_sgn[DIV_W].y_neg);
        axv = (cxv == '0) ? 16'sd1 : cxv;
        ayv = (cyv == '0) ? 16'sd1 : cyv;
        axm = axv[15] ? 17'(-$signed({axv[15], axv})) : {1'b0, axv};
        aym = ayv[15] ? 17'(-$signed({ayv[15], ayv})) : {1'b0, ayv};
        cor0_next.cx          = $signed({2'b00, aym, 14'b0});
        cor0_next.cy          = $signed({2'b00, axm, 14'b0});
        cor0_next.z           = '0;
        cor0_next.side.x_neg  = cxv[15];
        cor0_next.side.y_neg  = cyv[15];
        cor0_next.side.corr_x = cxv;
        cor0_next.side.corr_y = cyv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cor_valid[0] <= 1'b0;
        end
        else if (adv)
        begin
            cor_valid[0] <= div_valid[DIV_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cor[0] <= cor0_next;
        end
    end

    for (genvar i = 0; i < NCS; i++)
    begin : g_cordic
        chxy_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (cor_valid[i]),
            .in_data   (cor[i]),
            .out_valid (cor_valid[i+1]),
            .out_data  (cor[i+1])
        );
    end

    always_comb
    begin
        zc      = cor[NCS].z[chxy_pkg::Z_W-1] ? '0 : cor[NCS].z[25:0];
        zprod   = 43'(zc) * 43'(chxy_pkg::ANGLE_SCALE);
        rprod   = 38'(v_reg) * 38'(chxy_pkg::ANGLE_RECIP);
        a_clamp = (araw_reg > chxy_pkg::QUARTER_TURN) ? chxy_pkg::QUARTER_TURN : araw_reg;
        case ({f2_side_reg.x_neg, f2_side_reg.y_neg})
            2'b10:   ang_next = chxy_pkg::FULL_TURN - a_clamp;
            2'b11:   ang_next = chxy_pkg::HALF_TURN + a_clamp;
            2'b01:   ang_next = chxy_pkg::HALF_TURN - a_clamp;
            default: ang_next = a_clamp;
        endcase
        tprod = 25'(ang_reg) * 25'(chxy_pkg::TENTH_RECIP);
        hsum  = chxy_pkg::HEAD_BASE
              + $signed({{3{heading_offset_reg[9]}}, heading_offset_reg})
              - $signed({4'b0, tprod[24:16]});
        if (hsum >= 5 * chxy_pkg::DEG_360)
            hmod = hsum - 13'(5 * chxy_pkg::DEG_360);
        else if (hsum >= 4 * chxy_pkg::DEG_360)
            hmod = hsum - 13'(4 * chxy_pkg::DEG_360);
        else if (hsum >= 3 * chxy_pkg::DEG_360)
            hmod = hsum - 13'(3 * chxy_pkg::DEG_360);
        else if (hsum >= 2 * chxy_pkg::DEG_360)
            hmod = hsum - 13'(2 * chxy_pkg::DEG_360);
        else if (hsum >= chxy_pkg::DEG_360)
            hmod = hsum - chxy_pkg::DEG_360;
        else
            hmod = hsum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= '0;
        end
        else if (adv)
        begin
            fin_valid_reg <= {fin_valid_reg[2:0], cor_valid[NCS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg        <= zprod[42:24];
            f1_side_reg  <= cor[NCS].side;
            araw_reg     <= rprod[37:26];
            f2_side_reg  <= f1_side_reg;
            ang_reg      <= ang_next;
            f3_side_reg  <= f2_side_reg;
            out_ang_reg  <= ang_reg;
            out_head_reg <= hmod[8:0];
            out_cx_reg   <= f3_side_reg.corr_x;
            out_cy_reg   <= f3_side_reg.corr_y;
        end
    end

    assign m_tvalid = fin_valid_reg[3];
    assign m_tdata  = {3'b000, out_cy_reg, out_cx_reg, out_ang_reg, out_head_reg};

    `CHXY_ASSERT_NOW(a_head_range, !m_tvalid || (m_tdata[8:0] < 9'd360), "heading out of range")
    `CHXY_ASSERT_NOW(a_ang_range, !m_tvalid || (m_tdata[20:9] <= 12'd3600), "angle out of range")
    `CHXY_ASSERT_NOW(a_first_quad, !(m_tvalid && !m_tdata[36] && !m_tdata[52] && (m_tdata[36:21] != 16'd0) && (m_tdata[52:37] != 16'd0)) || (m_tdata[20:9] <= 12'd900), "first quadrant angle above 900")
    `CHXY_ASSERT_NEXT(a_stall_hold, !adv, $stable(div_valid) && $stable(cor_valid), "pipeline moved while stalled")

endmodule

// File: rtl/chxy_calib.sv
// Offset removal, gain cross products and skew correction ahead of the divider.
module chxy_calib #(
    parameter int SAMPLE_WIDTH = 16,
    localparam int DIV_W = SAMPLE_WIDTH + 20
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic signed [SAMPLE_WIDTH-1:0]          raw_x,
    input  logic signed [SAMPLE_WIDTH-1:0]          raw_y,
    input  logic signed [SAMPLE_WIDTH-1:0]          x_offset,
    input  logic signed [SAMPLE_WIDTH-1:0]          y_offset,
    input  logic [chxy_pkg::GAIN_W-1:0]             gx,
    input  logic [chxy_pkg::GAIN_W-1:0]             gy,
    input  logic signed [chxy_pkg::COEF_W-1:0]      sin_phi,
    input  logic [chxy_pkg::COEF_W-1:0]             inv_cos_phi,
    output logic                                    out_valid,
    output logic [DIV_W-1:0]                        x_word,
    output logic [DIV_W-1:0]                        y_word,
    output chxy_pkg::sign_t                         sgn
);

    localparam int SW = SAMPLE_WIDTH;

    logic [4:0] valid_reg;

    logic signed [SW:0]    dx_reg, dy_reg, dx_next, dy_next;
    logic signed [SW+16:0] pxg_reg, pys_reg, pyg_reg;
    logic signed [SW+16:0] pxg_next, pys_next, pyg_next, pyg_abs;
    logic signed [SW+16:0] pxg3_reg;
    logic signed [SW+32:0] t2_reg, t2_next, n_next, n_abs;
    logic [SW+15:0]        ymag3_reg, ymag4_reg, ymag3_next;
    logic                  yneg3_reg, yneg4_reg;
    logic [SW+31:0]        xmag_reg, xmag_next;
    logic                  xneg_reg;
    logic [SW+47:0]        xprod;
    logic [DIV_W-1:0]      x_word_reg, y_word_reg;
    chxy_pkg::sign_t       sgn_reg;

    always_comb
    begin
        dx_next  = $signed({raw_x[SW-1], raw_x}) - $signed({x_offset[SW-1], x_offset});
        dy_next  = $signed({raw_y[SW-1], raw_y}) - $signed({y_offset[SW-1], y_offset});
        pxg_next = dx_reg * $signed({1'b0, gy});
        pys_next = dy_reg * sin_phi;
        pyg_next = dy_reg * $signed({1'b0, gx});
        t2_next  = pys_reg * $signed({1'b0, gx});
        pyg_abs  = pyg_reg[SW+16] ? -pyg_reg : pyg_reg;
        ymag3_next = pyg_abs[SW+15:0];
        n_next   = $signed({pxg3_reg[SW+16], pxg3_reg, 15'b0}) - t2_reg;
        n_abs    = n_next[SW+32] ? -n_next : n_next;
        xmag_next = n_abs[SW+31:0];
        xprod    = (SW+48)'(xmag_reg) * (SW+48)'(inv_cos_phi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            pxg_reg    <= pxg_next;
            pys_reg    <= pys_next;
            pyg_reg    <= pyg_next;
            pxg3_reg   <= pxg_reg;
            t2_reg     <= t2_next;
            ymag3_reg  <= ymag3_next;
            yneg3_reg  <= pyg_reg[SW+16];
            xmag_reg   <= xmag_next;
            xneg_reg   <= n_next[SW+32];
            ymag4_reg  <= ymag3_reg;
            yneg4_reg  <= yneg3_reg;
            x_word_reg <= xprod[SW+47:28];
            y_word_reg <= DIV_W'(ymag4_reg);
            sgn_reg    <= '{x_neg: xneg_reg, y_neg: yneg4_reg};
        end
    end

    assign out_valid = valid_reg[4];
    assign x_word    = x_word_reg;
    assign y_word    = y_word_reg;
    assign sgn       = sgn_reg;

endmodule

// File: rtl/chxy_div_cell.sv
// One restoring-division cell: retires one quotient bit of both axes per stage.
module chxy_div_cell #(
    parameter int DIV_W = 36
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [chxy_pkg::GAIN_W-1:0]   gy,
    input  logic                          in_valid,
    input  logic [chxy_pkg::GAIN_W-1:0]   x_rem_in,
    input  logic [DIV_W-1:0]              x_w_in,
    input  logic [chxy_pkg::GAIN_W-1:0]   y_rem_in,
    input  logic [DIV_W-1:0]              y_w_in,
    input  chxy_pkg::sign_t               sgn_in,
    output logic                          out_valid,
    output logic [chxy_pkg::GAIN_W-1:0]   x_rem_out,
    output logic [DIV_W-1:0]              x_w_out,
    output logic [chxy_pkg::GAIN_W-1:0]   y_rem_out,
    output logic [DIV_W-1:0]              y_w_out,
    output chxy_pkg::sign_t               sgn_out
);

    localparam int GW = chxy_pkg::GAIN_W;

    logic                valid_reg;
    logic [GW-1:0]       x_rem_reg, y_rem_reg, x_rem_next, y_rem_next;
    logic [DIV_W-1:0]    x_w_reg, y_w_reg, x_w_next, y_w_next;
    chxy_pkg::sign_t     sgn_reg;
    logic [GW:0]         x_trial, y_trial, dvs;
    logic                x_ge, y_ge;

    always_comb
    begin
        dvs        = {1'b0, gy};
        x_trial    = {x_rem_in, x_w_in[DIV_W-1]};
        y_trial    = {y_rem_in, y_w_in[DIV_W-1]};
        x_ge       = x_trial >= dvs;
        y_ge       = y_trial >= dvs;
        x_rem_next = x_ge ? GW'(x_trial - dvs) : x_trial[GW-1:0];
        y_rem_next = y_ge ? GW'(y_trial - dvs) : y_trial[GW-1:0];
        x_w_next   = {x_w_in[DIV_W-2:0], x_ge};
        y_w_next   = {y_w_in[DIV_W-2:0], y_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_rem_reg <= x_rem_next;
            y_rem_reg <= y_rem_next;
            x_w_reg   <= x_w_next;
            y_w_reg   <= y_w_next;
            sgn_reg   <= sgn_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_rem_out = x_rem_reg;
    assign x_w_out   = x_w_reg;
    assign y_rem_out = y_rem_reg;
    assign y_w_out   = y_w_reg;
    assign sgn_out   = sgn_reg;

endmodule

// File: rtl/chxy_cordic_cell.sv
// One CORDIC vectoring cell with a fixed shift and its arctangent constant.
module chxy_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  chxy_pkg::cordic_t in_data,
    output logic              out_valid,
    output chxy_pkg::cordic_t out_data
);

    logic                                 valid_reg;
    chxy_pkg::cordic_t                    data_reg, data_next;
    logic signed [chxy_pkg::CORDIC_W-1:0] cx, cy, tx, ty;

    always_comb
    begin
        cx        = in_data.cx;
        cy        = in_data.cy;
        tx        = cx >>> STEP;
        ty        = cy >>> STEP;
        data_next = in_data;
        if (cy > 0)
        begin
            data_next.cx = cx + ty;
            data_next.cy = cy - tx;
            data_next.z  = in_data.z + chxy_pkg::atan_step(STEP);
        end
        else
        begin
            data_next.cx = cx - ty;
            data_next.cy = cy + tx;
            data_next.z  = in_data.z - chxy_pkg::atan_step(STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: tb/compass_heading_from_xy_tb.sv
// Self-checking testbench for the compass heading pipeline: stream stimulus, scoreboard check.
module compass_heading_from_xy_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [chxy_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int PIPE_DRAIN = 90;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PER_PHASE = 155;

    typedef struct {
        logic [chxy_pkg::HEAD_W-1:0]        hd;
        logic [chxy_pkg::ANG_W-1:0]         ang;
        logic signed [chxy_pkg::CORR_W-1:0] cx;
        logic signed [chxy_pkg::CORR_W-1:0] cy;
    } heading_t;

    class heading_scoreboard;
        logic signed [15:0]                 x_off, y_off;
        logic [chxy_pkg::GAIN_W-1:0]        x_gain, y_gain;
        logic signed [chxy_pkg::COEF_W-1:0] sin_phi;
        logic [chxy_pkg::COEF_W-1:0]        inv_cos;
        logic signed [chxy_pkg::HOFF_W-1:0] head_off;
        heading_t                           pending_q[$];
        int                                 fails;

        function new();
            x_off = '0; y_off = '0; x_gain = 15'd1; y_gain = 15'd1;
            sin_phi = '0; inv_cos = chxy_pkg::INV_COS_RESET; head_off = '0; fails = 0;
        endfunction

        function void write_reg(logic [chxy_pkg::CFG_IDX_W-1:0] idx,
                                logic [chxy_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                chxy_pkg::REG_X_OFFSET:       x_off = d[15:0];
                chxy_pkg::REG_Y_OFFSET:       y_off = d[15:0];
                chxy_pkg::REG_X_GAIN:         x_gain = d[chxy_pkg::GAIN_W-1:0];
                chxy_pkg::REG_Y_GAIN:         y_gain = d[chxy_pkg::GAIN_W-1:0];
                chxy_pkg::REG_SIN_PHI:        sin_phi = d[chxy_pkg::COEF_W-1:0];
                chxy_pkg::REG_INV_COS_PHI:    inv_cos = d[chxy_pkg::COEF_W-1:0];
                chxy_pkg::REG_HEADING_OFFSET: head_off = d[chxy_pkg::HOFF_W-1:0];
                default: ;
            endcase
        endfunction

        function longint sat16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function longint first_quadrant(longint num, longint den);
            longint vx, vy, z, tx, ty, a;
            vx = den * 16384;
            vy = num * 16384;
            z = 0;
            for (int i = 0; i < chxy_pkg::CORDIC_STEPS; i++)
            begin
                tx = vx >>> i;
                ty = vy >>> i;
                if (vy > 0)
                begin
                    vx += ty; vy -= tx; z += longint'(chxy_pkg::atan_step(i));
                end
                else
                begin
                    vx -= ty; vy += tx; z -= longint'(chxy_pkg::atan_step(i));
                end
            end
            if (z < 0) z = 0;
            a = (z * 90000) / (longint'(157) * 16777216);
            if (a > 900) a = 900;
            return a;
        endfunction

        function heading_t predict(logic signed [15:0] rx, logic signed [15:0] ry);
            heading_t r;
            longint dx, dy, gx, gy, s, c, n, q, rem, cxv, cyv, ax, ay, a, ang, hd;
            dx = longint'(rx) - longint'(x_off);
            dy = longint'(ry) - longint'(y_off);
            gx = (x_gain == 0) ? 1 : longint'(x_gain);
            gy = (y_gain == 0) ? 1 : longint'(y_gain);
            s = longint'(sin_phi);
            c = longint'(inv_cos);
            n = dx * gy * 32768 - dy * s * gx;
            q = n / gy;
            rem = n % gy;
            if (c == 0) cxv = 0;
            else if (q >= (longint'(1) << 44)) cxv = 32767;
            else if (q <= -(longint'(1) << 44)) cxv = -32768;
            else cxv = sat16((q * c + (rem * c) / gy) / (longint'(1) << 28));
            cyv = sat16((dy * gx) / gy);
            ax = (cxv == 0) ? 1 : cxv;
            ay = (cyv == 0) ? 1 : cyv;
            a = first_quadrant(ax < 0 ? -ax : ax, ay < 0 ? -ay : ay);
            if (ax < 0 && ay > 0) ang = 3600 - a;
            else if (ax < 0 && ay < 0) ang = 1800 + a;
            else if (ax > 0 && ay < 0) ang = 1800 - a;
            else ang = a;
            hd = (1530 + longint'(head_off) - ang / 10) % 360;
            r.hd = hd[chxy_pkg::HEAD_W-1:0];
            r.ang = ang[chxy_pkg::ANG_W-1:0];
            r.cx = cxv[chxy_pkg::CORR_W-1:0];
            r.cy = cyv[chxy_pkg::CORR_W-1:0];
            return r;
        endfunction

        function void note(logic signed [15:0] rx, logic signed [15:0] ry);
            pending_q.push_back(predict(rx, ry));
        endfunction

        function void check(logic [chxy_pkg::OUT_TDATA_W-1:0] td);
            heading_t e;
            if (pending_q.size() == 0)
            begin
                fails++;
                if (fails <= 10) $display("unexpected output transaction %h", td);
                return;
            end
            e = pending_q.pop_front();
            if (td[8:0] !== e.hd || td[20:9] !== e.ang || td[36:21] !== e.cx
                || td[52:37] !== e.cy)
            begin
                fails++;
                if (fails <= 10)
                    $display({"mismatch: exp hd=%0d ang=%0d cx=%0d cy=%0d",
                              " got hd=%0d ang=%0d cx=%0d cy=%0d"},
                        e.hd, e.ang, e.cx, e.cy, td[8:0], td[20:9],
                        $signed(td[36:21]), $signed(td[52:37]));
            end
        endfunction
    endclass

    logic                                  clk;
    logic                                  rst_n;
    logic                                  s_tvalid;
    logic                                  s_tready;
    logic [31:0]                           s_tdata;
    logic                                  m_tvalid;
    logic                                  m_tready;
    logic [chxy_pkg::OUT_TDATA_W-1:0]      m_tdata;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [chxy_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [chxy_pkg::CFG_DATA_W-1:0]       cfg_data;

    heading_scoreboard sb;
    bit long_hold;
    bit no_idle;
    int cycles;

    compass_heading_from_xy u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic send_sample(logic [15:0] rx, logic [15:0] ry);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ry, rx};
        do @(posedge clk); while (!s_tready);
        sb.note(rx, ry);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [chxy_pkg::CFG_IDX_W-1:0] idx,
                             logic [chxy_pkg::CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all(int xo, int yo, int gx, int gy, int sp, int ic, int ho, bit junk);
        logic [31:0] hi;
        hi = junk ? $urandom : 32'd0;
        write_reg(chxy_pkg::REG_X_OFFSET, {hi[31:16], 16'(xo)});
        write_reg(chxy_pkg::REG_Y_OFFSET, {hi[15:0], 16'(yo)});
        write_reg(chxy_pkg::REG_X_GAIN, {hi[31:15], 15'(gx)});
        write_reg(chxy_pkg::REG_Y_GAIN, {hi[16:0], 15'(gy)});
        write_reg(chxy_pkg::REG_SIN_PHI, {hi[31:16], 16'(sp)});
        write_reg(chxy_pkg::REG_INV_COS_PHI, {hi[15:0], 16'(ic)});
        write_reg(chxy_pkg::REG_HEADING_OFFSET, {hi[31:10], 10'(ho)});
        write_reg(REG_UNUSED, $urandom);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge clk);
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    task automatic random_phase(int count);
        int kind, span, rx, ry;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 3);
            span = $urandom_range(0, 1) ? 300 : 3000;
            case (kind)
                0:
                begin
                    rx = $urandom; ry = $urandom;
                end
                1:
                begin
                    rx = $urandom_range(0, 1) ? 32767 : -32768;
                    ry = $urandom_range(0, 1) ? 32767 : -32768;
                    if ($urandom_range(0, 1)) ry = int'(sb.y_off);
                end
                default:
                begin
                    rx = int'(sb.x_off) + $urandom_range(0, 2 * span) - span;
                    ry = int'(sb.y_off) + $urandom_range(0, 2 * span) - span;
                end
            endcase
            send_sample(16'(rx), 16'(ry));
        end
    endtask

    initial
    begin
        int dir_x[16] = '{0, 32767, -32768, -32768, 32767, 100, 0, -100, 0,
                          500, -500, -500, 500, 1, -1, 12345};
        int dir_y[16] = '{0, -32768, 32767, -32768, 32767, 0, 100, 0, -100,
                          500, 500, -500, -500, -1, 1, -23456};
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        long_hold = 0;
        no_idle = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 16; i++) send_sample(16'(dir_x[i]), 16'(dir_y[i]));
        drain();
        write_all(32767, 32767, 32767, 32767, 32767, 65535, 359, 0);
        for (int i = 0; i < 5; i++) send_sample(16'(dir_x[i]), 16'(dir_y[i]));
        drain();
        write_all(-32768, -32768, 0, 0, -32768, 0, -180, 0);
        for (int i = 0; i < 5; i++) send_sample(16'(dir_x[i]), 16'(dir_y[i]));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_all(0, 0, 1, 1, 0, 8192, 0, 1);
                1: write_all(-32768, 32767, 32767, 0, -32768, 65535, -180, 1);
                default:
                    write_all($urandom_range(0, 6000) - 3000, $urandom_range(0, 6000) - 3000,
                        $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4000),
                        $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4000),
                        $urandom_range(0, 16000) - 8000, $urandom_range(8192, 9500),
                        $urandom_range(0, 539) - 180, 1);
            endcase
            long_hold = (ph == 2);
            no_idle = (ph == 3);
            random_phase(RAND_PER_PHASE);
            drain();
        end

        if (sb.fails == 0 && sb.pending_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                long_hold = 0;
            end
            gap = draw_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check(m_tdata);
            @(negedge clk);
        end
    end

endmodule
